FILE: sv/tli_pkg.sv
// Shared types and constants for the two-line intersection block.
// No dependencies; imported by tli_divider and two_line_intersection.
package tli_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int TOL_WIDTH       = 63;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(4);

    typedef enum logic [1:0] {
        REL_PARALLEL   = 2'd0,
        REL_CROSS      = 2'd1,
        REL_COINCIDENT = 2'd2
    } relation_t;

    // travels alongside each item through the divider
    typedef struct packed {
        relation_t rel;
        logic      neg_x;
        logic      neg_y;
    } div_side_t;

endpackage

FILE: sv/tli_divider.sv
// Pipelined restoring divider: two numerators over one shared denominator.
// Stage 0 flags quotients of 2**Q_W or more, then one quotient bit per stage.
// Depends on tli_pkg.
module tli_divider
    import tli_pkg::*;
#(
    parameter int NUM_W = 3 * COORD_WIDTH_DEF + 3,
    parameter int DEN_W = 2 * COORD_WIDTH_DEF + 3,
    parameter int Q_W   = COORD_WIDTH_DEF
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             valid,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    input  div_side_t        side,
    output logic             quo_valid,
    output logic [Q_W-1:0]   quo_x,
    output logic [Q_W-1:0]   quo_y,
    output logic             over_x,
    output logic             over_y,
    output div_side_t        quo_side
);

    logic             valid_reg [0:Q_W];
    logic [NUM_W-1:0] rx_reg    [0:Q_W];
    logic [NUM_W-1:0] ry_reg    [0:Q_W];
    logic [Q_W-1:0]   qx_reg    [0:Q_W];
    logic [Q_W-1:0]   qy_reg    [0:Q_W];
    logic             ox_reg    [0:Q_W];
    logic             oy_reg    [0:Q_W];
    logic [DEN_W-1:0] den_reg   [0:Q_W];
    div_side_t        side_reg  [0:Q_W];

    logic [NUM_W-1:0] dsh  [1:Q_W];
    logic [NUM_W:0]   difx [1:Q_W];
    logic [NUM_W:0]   dify [1:Q_W];

    always_comb
    begin
        for (int s = 1; s <= Q_W; s++)
        begin
            dsh[s]  = NUM_W'(den_reg[s-1]) << (Q_W - s);
            difx[s] = {1'b0, rx_reg[s-1]} - {1'b0, dsh[s]};
            dify[s] = {1'b0, ry_reg[s-1]} - {1'b0, dsh[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= Q_W; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= valid;
            for (int s = 1; s <= Q_W; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= num_x;
            ry_reg[0]   <= num_y;
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            ox_reg[0]   <= num_x >= (NUM_W'(den) << Q_W);
            oy_reg[0]   <= num_y >= (NUM_W'(den) << Q_W);
            den_reg[0]  <= den;
            side_reg[0] <= side;
            for (int s = 1; s <= Q_W; s++)
            begin
                // borrow clear means the shifted divisor fits
                rx_reg[s] <= difx[s][NUM_W] ? rx_reg[s-1] : difx[s][NUM_W-1:0];
                ry_reg[s] <= dify[s][NUM_W] ? ry_reg[s-1] : dify[s][NUM_W-1:0];
                qx_reg[s] <= qx_reg[s-1]
                             | (difx[s][NUM_W] ? '0 : (Q_W'(1) << (Q_W - s)));
                qy_reg[s] <= qy_reg[s-1]
                             | (dify[s][NUM_W] ? '0 : (Q_W'(1) << (Q_W - s)));
                ox_reg[s]   <= ox_reg[s-1];
                oy_reg[s]   <= oy_reg[s-1];
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign quo_valid = valid_reg[Q_W];
    assign quo_x     = qx_reg[Q_W];
    assign quo_y     = qy_reg[Q_W];
    assign over_x    = ox_reg[Q_W];
    assign over_y    = oy_reg[Q_W];
    assign quo_side  = side_reg[Q_W];

endmodule

FILE: sv/two_line_intersection.sv
// Top level: intersection of two lines given by two points each, fixed point.
// Depends on tli_pkg and tli_divider.
//
//  channel     dir  handshake                  payload
//  item        in   item_valid / item_stall    a_start_x .. b_end_y
//  result      out  result_valid / result_stall relation, cross_x, cross_y, clipped
//  tolerance   in   tolerance_we               tolerance_data
//
// One item per cycle while item_stall is low. Six arithmetic stages,
// COORD_WIDTH + 1 divider stages (one quotient bit per stage), one output register.
// Reset clears all valid bits and loads tolerance with 4.
// A two-entry output buffer (head + skid) absorbs result_stall; the pipeline
// freezes only while the skid entry is occupied.
module two_line_intersection
    import tli_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tolerance_we,
    input  logic [TOL_WIDTH-1:0]          tolerance_data,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  logic signed [COORD_WIDTH-1:0] a_start_x,
    input  logic signed [COORD_WIDTH-1:0] a_start_y,
    input  logic signed [COORD_WIDTH-1:0] a_end_x,
    input  logic signed [COORD_WIDTH-1:0] a_end_y,
    input  logic signed [COORD_WIDTH-1:0] b_start_x,
    input  logic signed [COORD_WIDTH-1:0] b_start_y,
    input  logic signed [COORD_WIDTH-1:0] b_end_x,
    input  logic signed [COORD_WIDTH-1:0] b_end_y,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [1:0]                    relation,
    output logic signed [COORD_WIDTH-1:0] cross_x,
    output logic signed [COORD_WIDTH-1:0] cross_y,
    output logic                          clipped
);

    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;          // point differences
    localparam int PW    = 2 * DW;         // difference products
    localparam int DET_W = PW + 1;         // determinant
    localparam int CW    = 2 * W + 1;      // ca, cb
    localparam int FW    = CW + DW;        // ca * difference
    localparam int NW    = FW + 1;         // crossing numerators
    localparam int CMP_W = (DET_W > TOL_WIDTH) ? DET_W : TOL_WIDTH;
    localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;
    logic [TOL_WIDTH-1:0] tolerance_reg;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1
    logic signed [DW-1:0]  dxa1_reg, dya1_reg, dxb1_reg, dyb1_reg;
    logic signed [DW-1:0]  ex_reg, ey_reg, fx_reg, fy_reg;
    logic signed [2*W-1:0] pca1_reg, pca2_reg, pcb1_reg, pcb2_reg;
    // stage 2
    logic signed [PW-1:0]  pd1_reg, pd2_reg, po1_reg, po2_reg;
    logic signed [CW-1:0]  ca_reg, cb_reg;
    logic signed [DW-1:0]  dxa2_reg, dya2_reg, dxb2_reg, dyb2_reg;
    // stage 3
    logic signed [DET_W-1:0] det_reg, on_reg;
    logic signed [PW-1:0]  cxl_reg, cxh_reg, cyl_reg, cyh_reg;
    logic signed [PW-1:0]  bxl_reg, bxh_reg, byl_reg, byh_reg;
    // stage 4
    logic signed [FW-1:0]  pcx_reg, pcy_reg, pbx_reg, pby_reg;
    logic [DET_W-1:0]      det_mag4_reg, on_mag_reg;
    logic                  det_neg4_reg;
    // stage 5
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic [DET_W-1:0]      det_mag5_reg;
    logic                  det_neg5_reg;
    relation_t             rel5_reg;
    // stage 6
    logic [NW-1:0]         nx_mag_reg, ny_mag_reg;
    logic [DET_W-1:0]      det_mag6_reg;
    div_side_t             side6_reg;

    logic                  dq_valid;
    logic [W-1:0]          dq_x, dq_y;
    logic                  dq_over_x, dq_over_y;
    div_side_t             dq_side;

    relation_t             fmt_rel;
    logic signed [W-1:0]   fmt_x, fmt_y;
    logic                  fmt_clip, clip_x, clip_y;

    logic                  head_valid_reg, skid_valid_reg;
    relation_t             head_rel_reg, skid_rel_reg;
    logic signed [W-1:0]   head_x_reg, head_y_reg, skid_x_reg, skid_y_reg;
    logic                  head_clip_reg, skid_clip_reg;
    logic                  push, pop;

    assign en         = !skid_valid_reg;
    assign item_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
        end
        else if (tolerance_we)
        begin
            tolerance_reg <= tolerance_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // differences and the cross products of each line's endpoints
            dxa1_reg <= DW'(a_start_x) - DW'(a_end_x);
            dya1_reg <= DW'(a_start_y) - DW'(a_end_y);
            dxb1_reg <= DW'(b_start_x) - DW'(b_end_x);
            dyb1_reg <= DW'(b_start_y) - DW'(b_end_y);
            ex_reg   <= DW'(a_start_x) - DW'(b_start_x);
            ey_reg   <= DW'(a_start_y) - DW'(b_start_y);
            fx_reg   <= DW'(b_end_x) - DW'(b_start_x);
            fy_reg   <= DW'(b_end_y) - DW'(b_start_y);
            pca1_reg <= a_start_x * a_end_y;
            pca2_reg <= a_start_y * a_end_x;
            pcb1_reg <= b_start_x * b_end_y;
            pcb2_reg <= b_start_y * b_end_x;

            pd1_reg  <= dxa1_reg * dyb1_reg;
            pd2_reg  <= dya1_reg * dxb1_reg;
            po1_reg  <= ex_reg * fy_reg;
            po2_reg  <= fx_reg * ey_reg;
            ca_reg   <= CW'(pca1_reg) - CW'(pca2_reg);
            cb_reg   <= CW'(pcb1_reg) - CW'(pcb2_reg);
            dxa2_reg <= dxa1_reg;
            dya2_reg <= dya1_reg;
            dxb2_reg <= dxb1_reg;
            dyb2_reg <= dyb1_reg;

            // ca and cb split into unsigned low and signed high halves
            det_reg <= DET_W'(pd1_reg) - DET_W'(pd2_reg);
            on_reg  <= DET_W'(po1_reg) - DET_W'(po2_reg);
            cxl_reg <= $signed({1'b0, ca_reg[W-1:0]}) * dxb2_reg;
            cxh_reg <= $signed(ca_reg[CW-1:W]) * dxb2_reg;
            cyl_reg <= $signed({1'b0, ca_reg[W-1:0]}) * dyb2_reg;
            cyh_reg <= $signed(ca_reg[CW-1:W]) * dyb2_reg;
            bxl_reg <= $signed({1'b0, cb_reg[W-1:0]}) * dxa2_reg;
            bxh_reg <= $signed(cb_reg[CW-1:W]) * dxa2_reg;
            byl_reg <= $signed({1'b0, cb_reg[W-1:0]}) * dya2_reg;
            byh_reg <= $signed(cb_reg[CW-1:W]) * dya2_reg;

            pcx_reg      <= (FW'(cxh_reg) <<< W) + FW'(cxl_reg);
            pcy_reg      <= (FW'(cyh_reg) <<< W) + FW'(cyl_reg);
            pbx_reg      <= (FW'(bxh_reg) <<< W) + FW'(bxl_reg);
            pby_reg      <= (FW'(byh_reg) <<< W) + FW'(byl_reg);
            det_mag4_reg <= det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
            on_mag_reg   <= on_reg[DET_W-1] ? DET_W'(-on_reg) : DET_W'(on_reg);
            det_neg4_reg <= det_reg[DET_W-1];

            nx_reg       <= NW'(pcx_reg) - NW'(pbx_reg);
            ny_reg       <= NW'(pcy_reg) - NW'(pby_reg);
            det_mag5_reg <= det_mag4_reg;
            det_neg5_reg <= det_neg4_reg;
            if (CMP_W'(det_mag4_reg) > CMP_W'(tolerance_reg))
            begin
                rel5_reg <= REL_CROSS;
            end
            else if (CMP_W'(on_mag_reg) <= CMP_W'(tolerance_reg))
            begin
                rel5_reg <= REL_COINCIDENT;
            end
            else
            begin
                rel5_reg <= REL_PARALLEL;
            end

            nx_mag_reg      <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            ny_mag_reg      <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            det_mag6_reg    <= det_mag5_reg;
            side6_reg.rel   <= rel5_reg;
            side6_reg.neg_x <= nx_reg[NW-1] ^ det_neg5_reg;
            side6_reg.neg_y <= ny_reg[NW-1] ^ det_neg5_reg;
        end
    end

    tli_divider #(
        .NUM_W (NW),
        .DEN_W (DET_W),
        .Q_W   (W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid     (v6_reg),
        .num_x     (nx_mag_reg),
        .num_y     (ny_mag_reg),
        .den       (det_mag6_reg),
        .side      (side6_reg),
        .quo_valid (dq_valid),
        .quo_x     (dq_x),
        .quo_y     (dq_y),
        .over_x    (dq_over_x),
        .over_y    (dq_over_y),
        .quo_side  (dq_side)
    );

    // sign and saturation; a negative result may reach magnitude 2**(W-1)
    always_comb
    begin
        fmt_rel = dq_side.rel;
        if (dq_side.neg_x)
        begin
            clip_x = dq_over_x || (dq_x > COORD_MIN);
            fmt_x  = clip_x ? COORD_MIN : $signed(W'(0) - dq_x);
        end
        else
        begin
            clip_x = dq_over_x || dq_x[W-1];
            fmt_x  = clip_x ? COORD_MAX : $signed(dq_x);
        end
        if (dq_side.neg_y)
        begin
            clip_y = dq_over_y || (dq_y > COORD_MIN);
            fmt_y  = clip_y ? COORD_MIN : $signed(W'(0) - dq_y);
        end
        else
        begin
            clip_y = dq_over_y || dq_y[W-1];
            fmt_y  = clip_y ? COORD_MAX : $signed(dq_y);
        end
        fmt_clip = clip_x || clip_y;
        if (dq_side.rel != REL_CROSS)
        begin
            fmt_x    = '0;
            fmt_y    = '0;
            fmt_clip = 1'b0;
        end
    end

    assign push = dq_valid && en;
    assign pop  = head_valid_reg && !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            head_valid_reg <= 1'b1;
            if (head_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_rel_reg  <= skid_rel_reg;
                head_x_reg    <= skid_x_reg;
                head_y_reg    <= skid_y_reg;
                head_clip_reg <= skid_clip_reg;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg || pop)
            begin
                head_rel_reg  <= fmt_rel;
                head_x_reg    <= fmt_x;
                head_y_reg    <= fmt_y;
                head_clip_reg <= fmt_clip;
            end
            else
            begin
                skid_rel_reg  <= fmt_rel;
                skid_x_reg    <= fmt_x;
                skid_y_reg    <= fmt_y;
                skid_clip_reg <= fmt_clip;
            end
        end
    end

    assign result_valid = head_valid_reg;
    assign relation     = head_rel_reg;
    assign cross_x      = head_x_reg;
    assign cross_y      = head_y_reg;
    assign clipped      = head_clip_reg;

    a_no_cross_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && relation != REL_CROSS)
            |-> (cross_x == '0 && cross_y == '0 && !clipped))
        else $error("non-crossing item carries coordinates");

    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid entry occupied with empty head");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(head_valid_reg && result_stall))
        else $error("skid filled while head was free");

    a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && clipped)
            |-> (relation == REL_CROSS
                 && (cross_x == COORD_MAX || cross_x == COORD_MIN
                     || cross_y == COORD_MAX || cross_y == COORD_MIN)))
        else $error("clipped item without a saturated coordinate");

endmodule
